>>> src/mie_pkg.sv
// mie_pkg: shared types and constants for the integer execute block
// no dependencies; imported by the channel interfaces and the top level
package mie_pkg;

  // input item of the execute channel
  typedef struct packed {
    logic        func;
    logic [31:0] instr_word;
    logic [31:0] read_word_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] next_fetch_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [3:0]  byte_enable;
    logic [2:0]  status;
  } out_item_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_COMMIT,
    ST_FIN
  } state_e;

  localparam logic [31:0] RESET_VECTOR = 32'hBFC0_0000;

  // item kinds
  localparam logic FUNC_EXEC = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // memory request codes
  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_READ  = 2'd1;
  localparam logic [1:0] MOP_WRITE = 2'd2;

  // status codes
  localparam logic [2:0] STS_OK   = 3'd0;
  localparam logic [2:0] STS_OVF  = 3'd1;
  localparam logic [2:0] STS_ADEL = 3'd2;
  localparam logic [2:0] STS_ADES = 3'd3;
  localparam logic [2:0] STS_SYS  = 3'd4;
  localparam logic [2:0] STS_BRK  = 3'd5;
  localparam logic [2:0] STS_RSVD = 3'd6;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // load kinds (low bits of the load opcode)
  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LH  = 3'd1;
  localparam logic [2:0] LK_LWL = 3'd2;
  localparam logic [2:0] LK_LBU = 3'd4;
  localparam logic [2:0] LK_LHU = 3'd5;
  localparam logic [2:0] LK_LWR = 3'd6;

  localparam logic [4:0] REG_RA = 5'd31;

endpackage

>>> src/mie_if.sv
// mie_if: valid/ready channel interfaces for the execute block
// depends on mie_pkg for the payload types
interface mie_in_if;
  import mie_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mie_out_if;
  import mie_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/mips_i_integer_execute.sv
// mips_i_integer_execute: integer execute block with memory-based register file
// depends on mie_pkg and the channel interfaces in mie_if.sv
//
//  channel | dir | payload                                    | transfer
//  in_i    | in  | func, instr_word, read_word_in             | valid & ready
//  out_o   | out | next_fetch_pc, mem_op, mem_addr, mem_wdata,| valid & ready
//          |     | byte_enable, status                        |
//
// one item at a time: read register file, execute, commit, present result
// plain instructions step idle, exec, commit, fin; read data skips commit;
// multiply adds mul, divide adds div (restoring, one quotient bit per cycle)
// reset clears pc to the boot vector, hi/lo, pending state and all register
// valid bits, so registers never written read as zero; no clearing pass
// a result waiting on out_o stalls the next item only at its final step
module mips_i_integer_execute (
  input  logic             clk_i,
  input  logic             rst_ni,
  mie_in_if.sink           in_i,
  mie_out_if.source        out_o
);
  import mie_pkg::*;

  state_e state_q, state_d;

  // register file storage, read ports registered
  logic [31:0] gpr_mem [32];
  logic [31:0] vld_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic [4:0]  ra_q, rb_q;
  logic        gpr_we;
  logic [4:0]  gpr_wa;
  logic [31:0] gpr_wd;

  // architectural and pending state
  logic [31:0] pc_q, hi_q, lo_q, jt_q;
  logic        jp_q;
  logic        ld_vld_q;
  logic [2:0]  ld_kind_q;
  logic [1:0]  ld_boff_q;
  logic [4:0]  ld_dest_q;
  logic        dw_vld_q;
  logic [4:0]  dw_reg_q;
  logic [31:0] dw_val_q;
  logic        own_vld_q;
  logic [4:0]  own_reg_q;

  // item and result registers
  logic        func_q;
  logic [31:0] ins_q, rdw_q;
  out_item_t   res_q, out_q;
  logic        out_vld_q;

  // multiply and divide units
  logic [63:0] prod_q;
  logic        mul_sgn_q;
  logic [31:0] dv_q_q, dv_r_q, dv_b_q;
  logic [4:0]  dv_cnt_q;
  logic        dv_na_q, dv_nb_q;

  // control
  logic in_xfer, dw_commit, fin_load;

  assign in_xfer = in_i.valid & in_i.ready;

  // operand read with valid bits and zero register
  logic [31:0] va, vb;
  assign va = (ra_q != 5'd0 && vld_q[ra_q]) ? rd_a_q : 32'd0;
  assign vb = (rb_q != 5'd0 && vld_q[rb_q]) ? rd_b_q : 32'd0;

  // instruction fields
  logic [5:0]  opc, fn;
  logic [4:0]  ia, ib, id, sa;
  logic [31:0] simm, zimm, dslot, link, btgt, ea, sum, dif;
  logic [1:0]  lane;
  logic [4:0]  lsh;
  assign opc   = ins_q[31:26];
  assign fn    = ins_q[5:0];
  assign ia    = ins_q[25:21];
  assign ib    = ins_q[20:16];
  assign id    = ins_q[15:11];
  assign sa    = ins_q[10:6];
  assign simm  = {{16{ins_q[15]}}, ins_q[15:0]};
  assign zimm  = {16'd0, ins_q[15:0]};
  assign dslot = pc_q + 32'd4;
  assign link  = pc_q + 32'd8;
  assign btgt  = dslot + {simm[29:0], 2'b00};
  assign ea    = va + simm;
  assign lane  = ea[1:0];
  assign lsh   = {lane, 3'b000};
  assign sum   = va + vb;
  assign dif   = va - vb;

  // execute decode
  logic        x_wen, x_jmp, x_take, x_hi_we, x_lo_we, x_mul, x_div, x_sgn, x_ld;
  logic [4:0]  x_wreg;
  logic [31:0] x_wdata, x_jt, x_hi, x_lo, x_maddr, x_wdat, r_imm;
  logic [2:0]  x_st;
  logic [1:0]  x_mop;
  logic [3:0]  x_be;
  always_comb begin
    x_wen = 1'b0; x_wreg = id; x_wdata = 32'd0;
    x_jmp = 1'b0; x_jt = va; x_take = 1'b0;
    x_hi_we = 1'b0; x_lo_we = 1'b0; x_hi = va; x_lo = va;
    x_mul = 1'b0; x_div = 1'b0; x_sgn = 1'b0; x_ld = 1'b0;
    x_st = STS_OK; x_mop = MOP_NONE; x_maddr = 32'd0; x_wdat = 32'd0; x_be = 4'd0;
    r_imm = va + simm;
    case (opc)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin x_wen = 1'b1; x_wdata = vb << sa; end
          FN_SRL:  begin x_wen = 1'b1; x_wdata = vb >> sa; end
          FN_SRA:  begin x_wen = 1'b1; x_wdata = 32'($signed(vb) >>> sa); end
          FN_SLLV: begin x_wen = 1'b1; x_wdata = vb << va[4:0]; end
          FN_SRLV: begin x_wen = 1'b1; x_wdata = vb >> va[4:0]; end
          FN_SRAV: begin x_wen = 1'b1; x_wdata = 32'($signed(vb) >>> va[4:0]); end
          FN_JR:   x_jmp = 1'b1;
          FN_JALR: begin x_jmp = 1'b1; x_wen = 1'b1; x_wdata = link; end
          FN_SYSCALL: x_st = STS_SYS;
          FN_BREAK:   x_st = STS_BRK;
          FN_MFHI: begin x_wen = 1'b1; x_wdata = hi_q; end
          FN_MTHI: x_hi_we = 1'b1;
          FN_MFLO: begin x_wen = 1'b1; x_wdata = lo_q; end
          FN_MTLO: x_lo_we = 1'b1;
          FN_MULT:  begin x_mul = 1'b1; x_sgn = 1'b1; end
          FN_MULTU: x_mul = 1'b1;
          FN_DIV: begin
            if (vb == 32'd0) begin
              x_hi_we = 1'b1; x_lo_we = 1'b1;
              x_lo = va[31] ? 32'd1 : 32'hFFFF_FFFF;
            end else begin
              x_div = 1'b1; x_sgn = 1'b1;
            end
          end
          FN_DIVU: begin
            if (vb == 32'd0) begin
              x_hi_we = 1'b1; x_lo_we = 1'b1; x_lo = 32'hFFFF_FFFF;
            end else begin
              x_div = 1'b1;
            end
          end
          FN_ADD: begin
            if (~(va[31] ^ vb[31]) & (va[31] ^ sum[31])) x_st = STS_OVF;
            else begin x_wen = 1'b1; x_wdata = sum; end
          end
          FN_ADDU: begin x_wen = 1'b1; x_wdata = sum; end
          FN_SUB: begin
            if ((va[31] ^ vb[31]) & (va[31] ^ dif[31])) x_st = STS_OVF;
            else begin x_wen = 1'b1; x_wdata = dif; end
          end
          FN_SUBU: begin x_wen = 1'b1; x_wdata = dif; end
          FN_AND:  begin x_wen = 1'b1; x_wdata = va & vb; end
          FN_OR:   begin x_wen = 1'b1; x_wdata = va | vb; end
          FN_XOR:  begin x_wen = 1'b1; x_wdata = va ^ vb; end
          FN_NOR:  begin x_wen = 1'b1; x_wdata = ~(va | vb); end
          FN_SLT:  begin x_wen = 1'b1; x_wdata = {31'd0, $signed(va) < $signed(vb)}; end
          FN_SLTU: begin x_wen = 1'b1; x_wdata = {31'd0, va < vb}; end
          default: x_st = STS_RSVD;
        endcase
      end
      OP_REGIMM: begin
        x_take = ib[0] ? ~va[31] : va[31];
        if (ib[4]) begin x_wen = 1'b1; x_wreg = REG_RA; x_wdata = link; end
      end
      OP_J, OP_JAL: begin
        x_jmp = 1'b1;
        x_jt = {dslot[31:28], ins_q[25:0], 2'b00};
        if (opc == OP_JAL) begin x_wen = 1'b1; x_wreg = REG_RA; x_wdata = link; end
      end
      OP_BEQ:  x_take = (va == vb);
      OP_BNE:  x_take = (va != vb);
      OP_BLEZ: x_take = (va == 32'd0) | va[31];
      OP_BGTZ: x_take = ~((va == 32'd0) | va[31]);
      OP_ADDI: begin
        x_wreg = ib;
        if (~(va[31] ^ simm[31]) & (va[31] ^ r_imm[31])) x_st = STS_OVF;
        else begin x_wen = 1'b1; x_wdata = r_imm; end
      end
      OP_ADDIU: begin x_wreg = ib; x_wen = 1'b1; x_wdata = r_imm; end
      OP_SLTI: begin
        x_wreg = ib; x_wen = 1'b1; x_wdata = {31'd0, $signed(va) < $signed(simm)};
      end
      OP_SLTIU: begin x_wreg = ib; x_wen = 1'b1; x_wdata = {31'd0, va < simm}; end
      OP_ANDI: begin x_wreg = ib; x_wen = 1'b1; x_wdata = va & zimm; end
      OP_ORI:  begin x_wreg = ib; x_wen = 1'b1; x_wdata = va | zimm; end
      OP_XORI: begin x_wreg = ib; x_wen = 1'b1; x_wdata = va ^ zimm; end
      OP_LUI:  begin x_wreg = ib; x_wen = 1'b1; x_wdata = {ins_q[15:0], 16'd0}; end
      OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR: begin
        if (((opc == OP_LH || opc == OP_LHU) && ea[0]) || (opc == OP_LW && lane != 2'd0)) begin
          x_st = STS_ADEL; x_maddr = ea;
        end else begin
          x_ld = 1'b1; x_mop = MOP_READ; x_maddr = {ea[31:2], 2'b00};
        end
      end
      OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR: begin
        if ((opc == OP_SH && ea[0]) || (opc == OP_SW && lane != 2'd0)) begin
          x_st = STS_ADES; x_maddr = ea;
        end else begin
          x_mop = MOP_WRITE; x_maddr = {ea[31:2], 2'b00};
          case (opc)
            OP_SB: begin x_wdat = {24'd0, vb[7:0]} << lsh; x_be = 4'b0001 << lane; end
            OP_SH: begin x_wdat = {16'd0, vb[15:0]} << lsh; x_be = 4'b0011 << lane; end
            OP_SWL: begin
              x_wdat = vb >> (5'd24 - lsh);
              x_be = 4'((5'd2 << lane) - 5'd1);
            end
            OP_SW: begin x_wdat = vb; x_be = 4'hF; end
            default: begin x_wdat = vb << lsh; x_be = 4'hF << lane; end
          endcase
        end
      end
      default: x_st = STS_RSVD;
    endcase
    // a faulting instruction has no effect besides its status
    if (x_st != STS_OK) x_wen = 1'b0;
  end

  // load data alignment and merge
  logic [31:0] old_v, ld_val;
  logic [4:0]  bsh, hsh;
  assign old_v = (ld_dest_q != 5'd0 && vld_q[ld_dest_q]) ? rd_a_q : 32'd0;
  assign bsh = {ld_boff_q, 3'b000};
  assign hsh = {ld_boff_q[1], 4'b0000};
  always_comb begin
    case (ld_kind_q)
      LK_LB:  ld_val = {{24{rdw_q[bsh + 5'd7]}}, 8'(rdw_q >> bsh)};
      LK_LH:  ld_val = {{16{rdw_q[hsh + 5'd15]}}, 16'(rdw_q >> hsh)};
      LK_LWL: ld_val = (old_v & (32'h00FF_FFFF >> bsh)) | (rdw_q << (5'd24 - bsh));
      LK_LBU: ld_val = {24'd0, 8'(rdw_q >> bsh)};
      LK_LHU: ld_val = {16'd0, 16'(rdw_q >> hsh)};
      LK_LWR: ld_val = (old_v & (32'hFFFF_FF00 << (5'd24 - bsh))) | (rdw_q >> bsh);
      default: ld_val = rdw_q;
    endcase
  end

  // divider step
  logic [32:0] dv_t;
  logic        dv_ge;
  logic [31:0] dv_r_n, dv_q_n;
  assign dv_t   = {dv_r_q, dv_q_q[31]};
  assign dv_ge  = dv_t >= {1'b0, dv_b_q};
  assign dv_r_n = dv_ge ? 32'(dv_t - {1'b0, dv_b_q}) : dv_t[31:0];
  assign dv_q_n = {dv_q_q[30:0], dv_ge};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_EXEC;
      ST_EXEC: begin
        if (func_q == FUNC_DATA) state_d = ST_FIN;
        else if (x_mul && x_st == STS_OK) state_d = ST_MUL;
        else if (x_div) state_d = ST_DIV;
        else state_d = ST_COMMIT;
      end
      ST_MUL: state_d = ST_COMMIT;
      ST_DIV: if (dv_cnt_q == 5'd0) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_FIN;
      ST_FIN: if (!out_vld_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and register file write port
  always_comb begin
    in_i.ready = 1'b0;
    gpr_we = 1'b0;
    gpr_wa = x_wreg;
    gpr_wd = x_wdata;
    dw_commit = 1'b0;
    fin_load = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_EXEC: gpr_we = (func_q == FUNC_EXEC) && x_wen && (x_wreg != 5'd0);
      ST_COMMIT: begin
        dw_commit = dw_vld_q && dw_reg_q != 5'd0 && !(own_vld_q && own_reg_q == dw_reg_q);
        gpr_we = dw_commit;
        gpr_wa = dw_reg_q;
        gpr_wd = dw_val_q;
      end
      ST_FIN: fin_load = !out_vld_q || out_o.ready;
      default: ;
    endcase
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // register file memory
  always_ff @(posedge clk_i) begin
    if (gpr_we) gpr_mem[gpr_wa] <= gpr_wd;
    if (in_xfer) begin
      rd_a_q <= gpr_mem[(in_i.payload.func == FUNC_DATA) ? ld_dest_q
                                                       : in_i.payload.instr_word[25:21]];
      rd_b_q <= gpr_mem[in_i.payload.instr_word[20:16]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= in_i.payload.func;
      ins_q  <= in_i.payload.instr_word;
      rdw_q  <= in_i.payload.read_word_in;
      ra_q   <= in_i.payload.instr_word[25:21];
      rb_q   <= in_i.payload.instr_word[20:16];
    end
    if (state_q == ST_EXEC) begin
      prod_q    <= 64'(va) * 64'(vb);
      mul_sgn_q <= x_sgn;
      dv_na_q   <= x_sgn & va[31];
      dv_nb_q   <= x_sgn & vb[31];
      dv_q_q    <= (x_sgn & va[31]) ? 32'd0 - va : va;
      dv_b_q    <= (x_sgn & vb[31]) ? 32'd0 - vb : vb;
      dv_r_q    <= 32'd0;
      if (func_q == FUNC_DATA) begin
        res_q <= '{next_fetch_pc: pc_q, mem_op: MOP_NONE, mem_addr: 32'd0,
                   mem_wdata: 32'd0, byte_enable: 4'd0, status: STS_OK};
      end else begin
        res_q <= '{next_fetch_pc: jp_q ? jt_q : dslot, mem_op: x_mop, mem_addr: x_maddr,
                   mem_wdata: x_wdat, byte_enable: x_be, status: x_st};
      end
    end
    if (state_q == ST_DIV) begin
      dv_q_q <= dv_q_n;
      dv_r_q <= dv_r_n;
    end
    if (fin_load) out_q <= res_q;
    if (state_q == ST_EXEC && func_q == FUNC_DATA && ld_vld_q) begin
      dw_reg_q <= ld_dest_q;
      dw_val_q <= ld_val;
    end
    if (state_q == ST_EXEC && func_q == FUNC_EXEC) begin
      own_reg_q <= x_wreg;
      if (x_ld) begin
        ld_kind_q <= opc[2:0];
        ld_boff_q <= lane;
        ld_dest_q <= ib;
      end
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      pc_q      <= RESET_VECTOR;
      hi_q      <= '0;
      lo_q      <= '0;
      jp_q      <= 1'b0;
      jt_q      <= '0;
      ld_vld_q  <= 1'b0;
      dw_vld_q  <= 1'b0;
      own_vld_q <= 1'b0;
      dv_cnt_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gpr_we) vld_q[gpr_wa] <= 1'b1;
      if (state_q == ST_EXEC) begin
        if (func_q == FUNC_DATA) begin
          if (ld_vld_q) begin
            dw_vld_q <= 1'b1;
            ld_vld_q <= 1'b0;
          end
        end else begin
          pc_q      <= jp_q ? jt_q : dslot;
          jp_q      <= x_jmp | x_take;
          if (x_jmp | x_take) jt_q <= x_take ? btgt : x_jt;
          ld_vld_q  <= x_ld;
          own_vld_q <= x_wen;
          dv_cnt_q  <= 5'd31;
          if (x_hi_we) hi_q <= x_hi;
          if (x_lo_we) lo_q <= x_lo;
        end
      end
      // signed product correction
      if (state_q == ST_MUL) begin
        hi_q <= prod_q[63:32] - ((mul_sgn_q && va[31]) ? vb : 32'd0)
                              - ((mul_sgn_q && vb[31]) ? va : 32'd0);
        lo_q <= prod_q[31:0];
      end
      // divider iteration and sign fix on the last bit
      if (state_q == ST_DIV) begin
        dv_cnt_q <= dv_cnt_q - 5'd1;
        if (dv_cnt_q == 5'd0) begin
          lo_q <= (dv_na_q ^ dv_nb_q) ? 32'd0 - dv_q_n : dv_q_n;
          hi_q <= dv_na_q ? 32'd0 - dv_r_n : dv_r_n;
        end
      end
      if (state_q == ST_COMMIT) dw_vld_q <= 1'b0;
      if (fin_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // checks
  a_no_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gpr_we |-> gpr_wa != 5'd0) else $error("write to register zero");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_EXEC) else $error("accepted item not executed");
  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT |=> !dw_vld_q) else $error("delayed write left pending");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && dv_cnt_q == 5'd0) |=> state_q == ST_COMMIT)
    else $error("divider did not finish");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> out_vld_q) else $error("result not presented");

endmodule
